// ===== rtl/all_pairs_shortest_path_assert.svh =====
// Assertion macros for the all-pairs shortest path block.
// Used by rtl/all_pairs_shortest_path.sv; no other dependencies.
`ifndef ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH

`ifndef SYNTHESIS
`define APSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("apsp assertion failed");
`define APSP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("apsp assertion failed");
`else
`define APSP_ASSERT(lbl, prop)
`define APSP_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== rtl/apsp_pkg.sv =====
// Package for the all-pairs shortest path block: sizes and command codes.
// No dependencies; imported by apsp_alu and all_pairs_shortest_path.
`default_nettype none

package apsp_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int ADDR_W       = 2 * IDX_W;
  localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
  localparam int DIST_W       = 32;
  localparam int VCOUNT_W     = 5;
  localparam int CMD_W        = 2;
  localparam int NCNT_W       = (VCOUNT_W > IDX_W + 1) ? VCOUNT_W : IDX_W + 1;
  localparam int IN_DATA_W    = ((2 * IDX_W + DIST_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

endpackage

`default_nettype wire

// ===== rtl/apsp_alu.sv =====
// Shared relaxation unit: registered saturating add of two distances and
// a signed less-than of the held sum against a third. Uses apsp_pkg.
`default_nettype none

module apsp_alu
  import apsp_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     load_i,
  input  wire logic signed [DIST_W-1:0] a_i,
  input  wire logic signed [DIST_W-1:0] b_i,
  input  wire logic signed [DIST_W-1:0] c_i,
  output logic signed [DIST_W-1:0]      via_o,
  output logic                          less_o
);

  localparam logic signed [DIST_W-1:0] SAT_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] SAT_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  logic signed [DIST_W:0]   sum;
  logic signed [DIST_W-1:0] via_d;
  logic signed [DIST_W-1:0] via_q;

  always_comb begin
    sum = {a_i[DIST_W-1], a_i} + {b_i[DIST_W-1], b_i};
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      via_d = sum[DIST_W] ? SAT_MIN : SAT_MAX;
    end else begin
      via_d = sum[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      via_q <= via_d;
    end
  end

  assign via_o  = via_q;
  assign less_o = (via_q < c_i);

endmodule

`default_nettype wire

// ===== rtl/all_pairs_shortest_path.sv =====
// All-pairs shortest path (Floyd-Warshall) top level.
// Uses apsp_pkg, apsp_alu and all_pairs_shortest_path_assert.svh.
//
// Usage:
//   s_axis: one command per transaction. tuser = command (write, run, read).
//   tdata = row, col, weight from the low bit up. m_axis returns exactly one
//   transaction per command: tdata = distance (read data, else zero),
//   tuser = done flag (zero only for the unused command code).
//   cfg: writes vertex_count; write only while the block is idle.
// Sequence:
//   write: stored on accept, then the result; read: RAM read, then capture, then result.
//   run: each relaxed element passes RD_PAIR, RD_SELF and CMP, n*n*n elements in all, n
//   being vertex_count clamped to the matrix size; a run with n = 0 goes straight to done.
//   Each element needs two reads on the 2-read-port distance RAM, a third
//   read of the target entry and the shared add/compare unit.
//   One command is in flight at a time; s_axis_tready is high only when idle.
// Reset: vertex_count returns to 16; matrix contents are undefined until
//   written. Output stall: a finished result waits in the output register;
//   the next command is accepted meanwhile and its result holds until free.
`default_nettype none

module all_pairs_shortest_path
  import apsp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata,  // row, col, weight
  input  wire logic [CMD_W-1:0]     s_axis_tuser,  // command
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [DIST_W-1:0]         m_axis_tdata,  // distance
  output logic                      m_axis_tuser,  // done_res
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [VCOUNT_W-1:0]  cfg_data_i     // vertex_count
);

  `include "all_pairs_shortest_path_assert.svh"

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_READ    = 3'd1;
  localparam logic [2:0] ST_RD_PAIR = 3'd2;
  localparam logic [2:0] ST_RD_SELF = 3'd3;
  localparam logic [2:0] ST_CMP     = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  logic [2:0] state_q, state_d;
  logic [VCOUNT_W-1:0] vcount_q;
  logic [IDX_W-1:0] k_q, k_d, i_q, i_d, j_q, j_d;
  logic [DIST_W-1:0] res_dist_q, res_dist_d;
  logic res_done_q, res_done_d;
  logic m_valid_q, m_valid_d;
  logic [DIST_W-1:0] m_data_q;
  logic m_user_q;
  logic out_load;

  logic signed [DIST_W-1:0] mem_q [DEPTH];
  logic signed [DIST_W-1:0] rda_q, rdb_q;
  logic we, rea, reb;
  logic [ADDR_W-1:0] waddr, addra, addrb;
  logic signed [DIST_W-1:0] wdata;

  logic alu_load;
  logic signed [DIST_W-1:0] via;
  logic less;

  logic [IDX_W-1:0] in_row, in_col;
  logic signed [DIST_W-1:0] in_weight;
  logic [NCNT_W-1:0] n_use, n_last;
  logic in_accept;
  logic j_end, i_end, k_end;

  assign in_row    = s_axis_tdata[IDX_W-1:0];
  assign in_col    = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_weight = s_axis_tdata[2*IDX_W+DIST_W-1:2*IDX_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign n_use  = (NCNT_W'(vcount_q) > NCNT_W'(MAX_VERTICES)) ?
                  NCNT_W'(MAX_VERTICES) : NCNT_W'(vcount_q);
  assign n_last = n_use - NCNT_W'(1);
  assign j_end  = (NCNT_W'(j_q) == n_last);
  assign i_end  = (NCNT_W'(i_q) == n_last);
  assign k_end  = (NCNT_W'(k_q) == n_last);

  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  apsp_alu u_alu (
    .clk_i  (clk_i),
    .load_i (alu_load),
    .a_i    (rda_q),
    .b_i    (rdb_q),
    .c_i    (rda_q),
    .via_o  (via),
    .less_o (less)
  );

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    i_d        = i_q;
    j_d        = j_q;
    res_dist_d = res_dist_q;
    res_done_d = res_done_q;
    we         = 1'b0;
    rea        = 1'b0;
    reb        = 1'b0;
    waddr      = {i_q, j_q};
    wdata      = via;
    addra      = {i_q, j_q};
    addrb      = {k_q, j_q};
    alu_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_dist_d = '0;
          res_done_d = 1'b1;
          k_d        = '0;
          i_d        = '0;
          j_d        = '0;
          case (s_axis_tuser)
            CMD_WRITE: begin
              we      = 1'b1;
              waddr   = {in_row, in_col};
              wdata   = in_weight;
              state_d = ST_DONE;
            end
            CMD_RUN: begin
              state_d = (n_use == '0) ? ST_DONE : ST_RD_PAIR;
            end
            CMD_READ: begin
              rea     = 1'b1;
              addra   = {in_row, in_col};
              state_d = ST_READ;
            end
            default: begin
              res_done_d = 1'b0;
              state_d    = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        res_dist_d = rda_q;
        state_d    = ST_DONE;
      end
      ST_RD_PAIR: begin
        rea     = 1'b1;
        reb     = 1'b1;
        addra   = {i_q, k_q};
        addrb   = {k_q, j_q};
        state_d = ST_RD_SELF;
      end
      ST_RD_SELF: begin
        alu_load = 1'b1;
        rea      = 1'b1;
        addra    = {i_q, j_q};
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        we      = less;
        state_d = ST_RD_PAIR;
        if (!j_end) begin
          j_d = j_q + IDX_W'(1);
        end else begin
          j_d = '0;
          if (!i_end) begin
            i_d = i_q + IDX_W'(1);
          end else begin
            i_d = '0;
            if (!k_end) begin
              k_d = k_q + IDX_W'(1);
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rea) begin
      rda_q <= mem_q[addra];
    end
    if (reb) begin
      rdb_q <= mem_q[addrb];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vcount_q  <= VCOUNT_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    i_q        <= i_d;
    j_q        <= j_d;
    res_dist_q <= res_dist_d;
    res_done_q <= res_done_d;
    if (out_load) begin
      m_data_q <= res_dist_q;
      m_user_q <= res_done_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `APSP_ASSERT_NEXT(a_run_starts, in_accept && (s_axis_tuser == CMD_RUN) && (n_use != '0),
                    state_q == ST_RD_PAIR)
  `APSP_ASSERT(a_run_write_in_cmp, !(we && (state_q != ST_IDLE)) || (state_q == ST_CMP))
  `APSP_ASSERT(a_result_from_done, !$rose(m_axis_tvalid) || ($past(state_q) == ST_DONE))
  `APSP_ASSERT(a_not_done_zero, !(m_axis_tvalid && !m_axis_tuser) || (m_axis_tdata == '0))

endmodule

`default_nettype wire

// ===== verif/tb_all_pairs_shortest_path.sv =====
// Self-checking testbench for all_pairs_shortest_path: drives write, run, read and unused commands
// over the stream ports plus vertex_count writes, predicts every result with its own Floyd-Warshall model.
// Depends on rtl/apsp_pkg.sv and rtl/all_pairs_shortest_path.sv.
module tb_all_pairs_shortest_path;
  timeunit 1ns;
  timeprecision 1ps;
  import apsp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int STALL_LIMIT = 40000;
  localparam int LONG_HOLD   = 200;
  localparam int TAIL_CYCLES = 20;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_COUNTS [NUM_PHASES] = '{3, 1, 5, 2, 8, 4, 16, 6, 2, 7, 20, 4};
  localparam int PHASE_ITEMS = 48;
  localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              done;
  } result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;  // row, col, weight
  logic [CMD_W-1:0]     s_axis_tuser = '0;  // command
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DIST_W-1:0]    m_axis_tdata;       // distance
  logic                 m_axis_tuser;       // done_res
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [VCOUNT_W-1:0]  cfg_data_i = '0;

  int              dist_model [MAX_VERTICES][MAX_VERTICES];
  logic [VCOUNT_W-1:0] vcount_model = VCOUNT_RESET;
  result_t         expected_results [$];
  int              errors = 0;
  int              idle_cycles = 0;
  bit              tx_idle_on = 1'b0;
  bit              rx_idle_on = 1'b0;
  bit              long_hold_req = 1'b0;

  all_pairs_shortest_path dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int sat_sum(int a, int b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return int'(s);
  endfunction

  function automatic void relax_matrix();
    int n;
    int via;
    n = (vcount_model > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_model);
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          via = sat_sum(dist_model[i][k], dist_model[k][j]);
          if (via < dist_model[i][j]) dist_model[i][j] = via;
        end
  endfunction

  function automatic result_t predict_result(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] r,
                                             logic [IDX_W-1:0] c, logic [DIST_W-1:0] w);
    result_t res;
    res = '0;
    case (cmd)
      CMD_WRITE: begin
        dist_model[r][c] = int'(w);
        res.done = 1'b1;
      end
      CMD_RUN: begin
        relax_matrix();
        res.done = 1'b1;
      end
      CMD_READ: begin
        res.distance = dist_model[r][c];
        res.done = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void note_error(string what, result_t want, result_t got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s: expected distance %0d done %0b, got distance %0d done %0b", $realtime,
               what, $signed(want.distance), want.done, $signed(got.distance), got.done);
  endfunction

  always @(posedge clk_i) begin : monitor_blk
    result_t got;
    result_t want;
    bit progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_model = cfg_data_i;
        progress = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        progress = 1'b1;
        got.distance = m_axis_tdata;
        got.done = m_axis_tuser;
        if (expected_results.size() == 0) begin
          note_error("result with nothing pending", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.distance !== want.distance) note_error("distance mismatch", want, got);
          else if (got.done !== want.done) note_error("done flag mismatch", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        progress = 1'b1;
        expected_results.push_back(predict_result(s_axis_tuser, s_axis_tdata[IDX_W-1:0],
                                                  s_axis_tdata[2*IDX_W-1:IDX_W],
                                                  s_axis_tdata[2*IDX_W +: DIST_W]));
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // result side: random stalls plus an on-demand long hold
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 17);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                          logic [DIST_W-1:0] w);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[IDX_W-1:0] = r;
    word[2*IDX_W-1:IDX_W] = c;
    word[2*IDX_W +: DIST_W] = w;
    @(negedge clk_i);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(logic [VCOUNT_W-1:0] count);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [DIST_W-1:0] pick_weight();
    case ($urandom_range(0, 19))
      0: return $urandom();
      1: return ($urandom_range(0, 1) != 0) ? DIST_MAX : DIST_MIN;
      2: return 32'h7FFF_0000 | 32'($urandom_range(0, 16'hFFFF));
      3: return 32'($urandom_range(0, 50)) - 32'd60;
      default: return 32'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic test_load_matrix();
    for (int r = 0; r < MAX_VERTICES; r++)
      for (int c = 0; c < MAX_VERTICES; c++)
        send_cmd(CMD_WRITE, IDX_W'(r), IDX_W'(c),
                 (r == c) ? 32'd0 : 32'($urandom_range(1, 1000)));
  endtask

  task automatic test_count_extremes();
    write_vertex_count(5'd0);
    send_cmd(CMD_RUN, '0, '0, '0);
    send_cmd(CMD_READ, 4'd1, 4'd2, '0);
    write_vertex_count(5'd1);
    send_cmd(CMD_RUN, 4'hF, 4'hF, '1);
    write_vertex_count(5'd31);
    send_cmd(CMD_RUN, '0, '0, '0);
    send_cmd(CMD_READ, 4'd15, 4'd0, '0);
    send_cmd(CMD_READ, 4'd7, 4'd9, '0);
  endtask

  task automatic test_edge_values();
    write_vertex_count(5'd16);
    send_cmd(CMD_WRITE, 4'd15, 4'd15, DIST_MIN);
    send_cmd(CMD_WRITE, 4'd0, 4'd15, DIST_MAX);
    send_cmd(CMD_WRITE, 4'd15, 4'd0, 32'hAAAA_AAAA);
    send_cmd(CMD_READ, 4'd15, 4'd15, '1);
    send_cmd(CMD_READ, 4'd0, 4'd15, '0);
    send_cmd(CMD_READ, 4'd15, 4'd0, '0);
    send_cmd(CMD_NONE, '1, '1, '1);
    send_cmd(CMD_NONE, '0, '0, 32'h5555_5555);
  endtask

  task automatic test_saturation();
    write_vertex_count(5'd2);
    send_cmd(CMD_WRITE, 4'd0, 4'd0, 32'd0);
    send_cmd(CMD_WRITE, 4'd0, 4'd1, DIST_MAX);
    send_cmd(CMD_WRITE, 4'd1, 4'd0, DIST_MAX);
    send_cmd(CMD_WRITE, 4'd1, 4'd1, 32'd0);
    send_cmd(CMD_RUN, '0, '0, '0);
    send_cmd(CMD_READ, 4'd1, 4'd1, '0);
    send_cmd(CMD_WRITE, 4'd0, 4'd1, DIST_MIN);
    send_cmd(CMD_WRITE, 4'd1, 4'd0, -32'sd5);
    send_cmd(CMD_RUN, '0, '0, '0);
    send_cmd(CMD_READ, 4'd0, 4'd0, '0);
    send_cmd(CMD_READ, 4'd1, 4'd0, '0);
  endtask

  task automatic test_backpressure();
    write_vertex_count(5'd4);
    rx_idle_on = 1'b0;
    @(negedge clk_i);
    long_hold_req = 1'b1;
    for (int i = 0; i < 6; i++)
      send_cmd(($urandom_range(0, 1) != 0) ? CMD_READ : CMD_WRITE,
               IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)), pick_weight());
    send_cmd(CMD_RUN, '0, '0, '0);
    drain_results();
  endtask

  task automatic test_random_phases();
    int n;
    int runs_left;
    int sel;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_vertex_count(VCOUNT_W'(PHASE_COUNTS[p]));
      tx_idle_on = (p < NUM_PHASES - 2);
      rx_idle_on = (p < NUM_PHASES - 2);
      n = (PHASE_COUNTS[p] > MAX_VERTICES) ? MAX_VERTICES : PHASE_COUNTS[p];
      runs_left = (n >= 12) ? 1 : PHASE_ITEMS;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && $urandom_range(0, 1) != 0) drain_results();
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          cmd = CMD_WRITE;
        end else if (sel < 85) begin
          cmd = CMD_READ;
        end else if (sel < 95 && runs_left > 0) begin
          cmd = CMD_RUN;
          runs_left--;
        end else if (sel < 95) begin
          cmd = CMD_READ;
        end else begin
          cmd = CMD_NONE;
        end
        if (n > 0 && $urandom_range(0, 99) < 85) begin
          r = IDX_W'($urandom_range(0, n - 1));
          c = IDX_W'($urandom_range(0, n - 1));
        end else begin
          r = IDX_W'($urandom_range(0, 15));
          c = IDX_W'($urandom_range(0, 15));
        end
        send_cmd(cmd, r, c, pick_weight());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_load_matrix();
    test_count_extremes();
    test_edge_values();
    test_saturation();
    test_backpressure();
    test_random_phases();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/apsp_pkg.sv
rtl/apsp_alu.sv
rtl/all_pairs_shortest_path.sv
verif/tb_all_pairs_shortest_path.sv
